// ===== hw/rtl/svpwm_mmd_pkg.sv =====
// Shared types, widths and constants for the SVPWM min-max duty calculator.
package svpwm_mmd_pkg;

  localparam int PW      = 34;  // phase voltage, signed
  localparam int DW      = 35;  // phase offset from midpoint, signed
  localparam int RW      = 34;  // min-max spread, unsigned
  localparam int NW      = 52;  // division numerator and remainder
  localparam int QW      = 17;  // quotient magnitude
  localparam int SW      = 19;  // signed duty before clamp
  localparam int STEP_W  = 5;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;
  localparam int FIFO_CW    = 2;
  localparam int ADDR_W     = 3;

  localparam logic [16:0]       SQRT3_HALF     = 17'd56756;
  localparam logic [15:0]       BUS_FLOOR      = 16'd128;
  localparam logic [15:0]       MAX_DUTY_RESET = 16'd62259;
  localparam logic [ADDR_W-1:0] ADDR_MAX_DUTY  = 3'd0;

  typedef struct packed {
    logic signed [DW-1:0] d_a;
    logic signed [DW-1:0] d_b;
    logic signed [DW-1:0] d_c;
    logic [RW-1:0]        span;
    logic [15:0]          bus;
    logic                 scaled;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_NUM,
    BK_DIV,
    BK_FIX,
    BK_OUT
  } back_state_e;

  // 2*max_duty - 1.0 in Q0.16, held at zero when max_duty is not above one half
  function automatic logic [15:0] duty_factor(input logic [15:0] md);
    logic [15:0] f;
    f = md[15] ? {md[14:0], 1'b0} : 16'd0;
    return f;
  endfunction

endpackage

// ===== hw/rtl/svpwm_min_max_duty_calculator_unit.sv =====
// Top level of the SVPWM min-max duty calculator: register port and part wiring.
//
//  channel   handshake               words
//  input     push / full             v_alpha_i, v_beta_i, bus_voltage_i
//  result    empty / pop             duty_a_o, duty_b_o, duty_c_o
//  config    psel/penable/pwrite     max_duty at byte address 0
//
// A word passes the front pipeline, then the back part: three phases in
// turn through the one shared shift-subtract divider (17 quotient bits),
// plus load and hand-over. The back part takes a new word only once it is
// done with the last one, and it waits in hand-over while the result is full.
// Reset clears the pipeline, queue and result flags and loads max_duty.
// Two words queue between front and back; a full result register holds
// the back part while the front keeps accepting until the queue is full.
module svpwm_min_max_duty_calculator_unit import svpwm_mmd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] v_alpha_i,
  input  logic signed [15:0] v_beta_i,
  input  logic [15:0]        bus_voltage_i,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        duty_a_o,
  output logic [15:0]        duty_b_o,
  output logic [15:0]        duty_c_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] max_duty_q;
  logic        q_full, q_empty, q_push, q_pop;
  job_t        q_wjob, q_rjob;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_DUTY) ? {16'd0, max_duty_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_duty_q <= MAX_DUTY_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_MAX_DUTY) begin
      max_duty_q <= pwdata[15:0];
    end
  end

  svpwm_mmd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .stall_o       (full),
    .v_alpha_i     (v_alpha_i),
    .v_beta_i      (v_beta_i),
    .bus_voltage_i (bus_voltage_i),
    .max_duty_i    (max_duty_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (q_wjob)
  );

  svpwm_mmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_push),
    .wdata_i (q_wjob),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .rdata_o (q_rjob),
    .empty_o (q_empty)
  );

  svpwm_mmd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_duty_i (max_duty_q),
    .q_empty_i  (q_empty),
    .q_job_i    (q_rjob),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .duty_a_o   (duty_a_o),
    .duty_b_o   (duty_b_o),
    .duty_c_o   (duty_c_o)
  );

endmodule

// ===== hw/rtl/svpwm_mmd_front.sv =====
// Front pipeline: inverse Clarke, min/max, spread test and midpoint offsets.
module svpwm_mmd_front import svpwm_mmd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               stall_o,
  input  logic signed [15:0] v_alpha_i,
  input  logic signed [15:0] v_beta_i,
  input  logic [15:0]        bus_voltage_i,
  input  logic [15:0]        max_duty_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output job_t               q_job_o
);

  logic v1_q, v2_q, v3_q;
  logic adv;

  logic signed [15:0] va1_q, vb1_q;
  logic [15:0]        bus1_q, bus2_q, bus3_q;
  logic signed [PW-1:0] pa2_q, pb2_q, pc2_q, pa3_q, pb3_q, pc3_q;
  logic signed [PW-1:0] mn3_q, mx3_q;
  logic [31:0] fb2_q, fb3_q;

  logic signed [32:0]   kb_c;
  logic signed [PW-1:0] va_ext, pa_c, pb_c, pc_c, mn_c, mx_c;
  logic [31:0]          fb_c;
  logic signed [PW-1:0] span_c;

  assign adv     = !(v3_q && q_full_i);
  assign stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 2: phase voltages and the spread limit product
  assign va_ext = PW'(va1_q);
  assign kb_c   = $signed({1'b0, SQRT3_HALF}) * vb1_q;
  assign pa_c   = va_ext <<< 16;
  assign pb_c   = -(va_ext <<< 15) + PW'(kb_c);
  assign pc_c   = -(va_ext <<< 15) - PW'(kb_c);
  assign fb_c   = duty_factor(max_duty_i) * bus1_q;

  // stage 3: extremes
  always_comb begin
    mn_c = pa2_q;
    mx_c = pa2_q;
    if (pb2_q < mn_c) mn_c = pb2_q;
    if (pc2_q < mn_c) mn_c = pc2_q;
    if (pb2_q > mx_c) mx_c = pb2_q;
    if (pc2_q > mx_c) mx_c = pc2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      va1_q  <= v_alpha_i;
      vb1_q  <= v_beta_i;
      bus1_q <= (bus_voltage_i < BUS_FLOOR) ? BUS_FLOOR : bus_voltage_i;
      pa2_q  <= pa_c;
      pb2_q  <= pb_c;
      pc2_q  <= pc_c;
      fb2_q  <= fb_c;
      bus2_q <= bus1_q;
      pa3_q  <= pa2_q;
      pb3_q  <= pb2_q;
      pc3_q  <= pc2_q;
      mn3_q  <= mn_c;
      mx3_q  <= mx_c;
      fb3_q  <= fb2_q;
      bus3_q <= bus2_q;
    end
  end

  // spread, scale decision and offsets from the midpoint
  assign span_c = mx3_q - mn3_q;

  always_comb begin
    q_job_o.span   = RW'(span_c);
    q_job_o.bus    = bus3_q;
    q_job_o.scaled = 50'(RW'(span_c)) > 50'({fb3_q, 16'd0});
    q_job_o.d_a    = (DW'(pa3_q) <<< 1) - DW'(mn3_q) - DW'(mx3_q);
    q_job_o.d_b    = (DW'(pb3_q) <<< 1) - DW'(mn3_q) - DW'(mx3_q);
    q_job_o.d_c    = (DW'(pc3_q) <<< 1) - DW'(mn3_q) - DW'(mx3_q);
  end

  assign q_push_o = v3_q && !q_full_i;

endmodule

// ===== hw/rtl/svpwm_mmd_fifo.sv =====
// Short queue of classified words between the front and back parts.
module svpwm_mmd_fifo import svpwm_mmd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wdata_i,
  output logic full_o,
  input  logic rd_i,
  output job_t rdata_o,
  output logic empty_o
);

  job_t mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [FIFO_CW-1:0] cnt_q;

  assign full_o  = cnt_q == FIFO_CW'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      if (wr_i && !rd_i) cnt_q <= cnt_q + 1'b1;
      else if (rd_i && !wr_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

endmodule

// ===== hw/rtl/svpwm_mmd_back.sv =====
// Back part: per-phase scaling divide, rounding, clamp and output register.
module svpwm_mmd_back import svpwm_mmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] max_duty_i,
  input  logic        q_empty_i,
  input  job_t        q_job_i,
  output logic        q_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [15:0] duty_a_o,
  output logic [15:0] duty_b_o,
  output logic [15:0] duty_c_o
);

  back_state_e state_q, state_d;
  logic [1:0]  idx_q, idx_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic        out_v_q, out_v_d;

  job_t               job_q;
  logic signed [NW-1:0] prod_q;
  logic [NW-1:0]      rem_q, den_q;
  logic [QW-1:0]      quo_q;
  logic               neg_q;
  logic [15:0]        res_q [3];
  logic [15:0]        da_q, db_q, dc_q;

  logic signed [DW-1:0] d_sel;
  logic [15:0]          factor_c;
  logic signed [NW-1:0] mul_c, num_c;
  logic [NW-1:0]        add_c;
  logic [DW-1:0]        den_base;
  logic [QW:0]          q_inc;
  logic signed [SW-1:0] qs_c, duty_c;
  logic [15:0]          clamp_c;
  logic                 slot_free;

  assign factor_c  = duty_factor(max_duty_i);
  assign slot_free = !out_v_q || pop_i;

  always_comb begin
    case (idx_q)
      2'd0:    d_sel = job_q.d_a;
      2'd1:    d_sel = job_q.d_b;
      default: d_sel = job_q.d_c;
    endcase
  end

  assign mul_c    = d_sel * $signed({1'b0, factor_c});
  assign add_c    = job_q.scaled ? NW'(job_q.span) : NW'({job_q.bus, 17'd0});
  assign num_c    = prod_q + $signed(add_c);
  assign den_base = job_q.scaled ? DW'({job_q.span, 1'b0}) : DW'({job_q.bus, 18'd0});

  // floor of the signed quotient, then offset by one half and clamp
  assign q_inc  = {1'b0, quo_q} + 1'b1;
  assign qs_c   = !neg_q ? SW'(quo_q) :
                  (rem_q != '0) ? -SW'(q_inc) : -SW'(quo_q);
  assign duty_c = qs_c + SW'(32768);
  assign clamp_c = duty_c[SW-1] ? 16'd0 :
                   (duty_c > $signed({3'b0, max_duty_i})) ? max_duty_i : duty_c[15:0];

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    step_d  = step_q;
    out_v_d = out_v_q && !pop_i;
    q_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          idx_d   = 2'd0;
          state_d = BK_MUL;
        end
      end
      BK_MUL:  state_d = BK_NUM;
      BK_NUM: begin
        step_d  = STEP_W'(QW - 1);
        state_d = BK_DIV;
      end
      BK_DIV: begin
        step_d = step_q - 1'b1;
        if (step_q == '0) state_d = BK_FIX;
      end
      BK_FIX: begin
        if (idx_q == 2'd2) begin
          state_d = BK_OUT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = BK_MUL;
        end
      end
      BK_OUT: begin
        if (slot_free) begin
          out_v_d = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= 2'd0;
      step_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: if (!q_empty_i) job_q <= q_job_i;
      BK_MUL:  prod_q <= job_q.scaled ? mul_c : (NW'(d_sel) <<< 1);
      BK_NUM: begin
        neg_q <= num_c[NW-1];
        rem_q <= num_c[NW-1] ? NW'(-num_c) : NW'(num_c);
        den_q <= NW'(den_base) << (QW - 1);
        quo_q <= '0;
      end
      BK_DIV: begin
        // one quotient bit per step, largest first
        if (rem_q >= den_q) begin
          rem_q <= rem_q - den_q;
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
        den_q <= den_q >> 1;
      end
      BK_FIX:  res_q[idx_q] <= clamp_c;
      BK_OUT: begin
        if (slot_free) begin
          da_q <= res_q[0];
          db_q <= res_q[1];
          dc_q <= res_q[2];
        end
      end
      default: ;
    endcase
  end

  assign empty_o  = !out_v_q;
  assign duty_a_o = da_q;
  assign duty_b_o = db_q;
  assign duty_c_o = dc_q;

endmodule

// ===== test/svpwm_min_max_duty_calculator_unit_tb.sv =====
// Self-checking testbench for the SVPWM min-max duty calculator unit.
module svpwm_min_max_duty_calculator_unit_tb import svpwm_mmd_pkg::*;;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] v_alpha_i = '0;
  logic signed [15:0] v_beta_i = '0;
  logic [15:0]        bus_voltage_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [15:0]        duty_a_o, duty_b_o, duty_c_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } duties_t;

  duties_t     duty_q[$];
  logic [15:0] max_duty_shadow = MAX_DUTY_RESET;
  int          n_errors = 0;
  int          quiet_cycles = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          rx_hold_req = 1'b0;

  svpwm_min_max_duty_calculator_unit u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint floor_div(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic longint round_div(longint num, longint den);
    return floor_div(2 * num + den, 2 * den);
  endfunction

  // Inverse Clarke, proportional limit, midpoint injection, bus divide, clamp
  function automatic duties_t calc_duties(logic signed [15:0] va, logic signed [15:0] vb,
                                          logic [15:0] bus_raw, logic [15:0] md);
    longint ph[3];
    longint vmin, vmax, span, fac, bus, lim, d, duty, top;
    logic [15:0] res[3];
    duties_t r;
    ph[0] = longint'(va) * 65536;
    ph[1] = -longint'(va) * 32768 + 56756 * longint'(vb);
    ph[2] = -longint'(va) * 32768 - 56756 * longint'(vb);
    vmin = ph[0];
    vmax = ph[0];
    for (int i = 1; i < 3; i++) begin
      if (ph[i] < vmin) vmin = ph[i];
      if (ph[i] > vmax) vmax = ph[i];
    end
    span = vmax - vmin;
    bus = (bus_raw < 128) ? 128 : longint'(bus_raw);
    top = longint'(md);
    fac = 2 * top - 65536;
    if (fac < 0) fac = 0;
    lim = fac * bus * 65536;
    for (int i = 0; i < 3; i++) begin
      d = 2 * ph[i] - vmin - vmax;
      if (span > lim) duty = 32768 + round_div(d * fac, 2 * span);
      else duty = 32768 + round_div(d, 2 * bus * 65536);
      if (duty > top) duty = top;
      if (duty < 0) duty = 0;
      res[i] = duty[15:0];
    end
    r.a = res[0];
    r.b = res[1];
    r.c = res[2];
    return r;
  endfunction

  task automatic write_max_duty(logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_DUTY;
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_duty_shadow = value;
  endtask

  task automatic send_word(logic signed [15:0] va, logic signed [15:0] vb, logic [15:0] bus);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    push          <= 1'b1;
    v_alpha_i     <= va;
    v_beta_i      <= vb;
    bus_voltage_i <= bus;
    do @(posedge clk_i); while (full);
    duty_q.push_back(calc_duties(va, vb, bus, max_duty_shadow));
  endtask

  // Wait for every expected word, then let the pipeline drain
  task automatic settle();
    push <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random(int n, bit low_bus);
    logic [15:0] bus;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: bus = 16'($urandom_range(0, 255));
        1: bus = 16'($urandom_range(0, 65535));
        default: bus = low_bus ? 16'($urandom_range(0, 2000)) :
                                 16'($urandom_range(1000, 65535));
      endcase
      if ($urandom_range(0, 1)) send_word(16'($urandom), 16'($urandom), bus);
      else send_word($signed(16'($urandom_range(0, 4000)) - 16'sd2000),
                     $signed(16'($urandom_range(0, 4000)) - 16'sd2000), bus);
    end
  endtask

  task automatic test_extremes();
    send_word(16'sd0, 16'sd0, 16'd0);
    send_word(16'sd0, 16'sd0, 16'hffff);
    send_word(16'sh7fff, 16'sh7fff, 16'hffff);
    send_word(-16'sh8000, -16'sh8000, 16'hffff);
    send_word(16'sh7fff, -16'sh8000, 16'd0);
    send_word(-16'sh8000, 16'sh7fff, 16'd127);
    send_word(16'sd100, 16'sd0, 16'd128);
    send_word(16'sd100, 16'sd50, 16'd129);
    send_word(16'sd1, -16'sd1, 16'd0);
    send_word(16'sh5555, 16'shaaaa, 16'h5555);
    send_word(16'shaaaa, 16'sh5555, 16'haaaa);
    send_word(16'sd0, 16'sh7fff, 16'd4096);
    send_word(16'sd500, -16'sd300, 16'd20000);
    settle();
  endtask

  task automatic test_max_duty_settings();
    logic [15:0] settings[5] = '{16'hffff, 16'd32769, 16'd32768, 16'd0, 16'd40000};
    foreach (settings[k]) begin
      write_max_duty(settings[k]);
      send_word(16'sd0, 16'sd0, 16'd1000);
      send_word(16'sd300, 16'sd200, 16'd1000);
      send_word(-16'sd300, 16'sd700, 16'd0);
      send_random(8, 1'b1);
      settle();
    end
  endtask

  task automatic test_random();
    write_max_duty(MAX_DUTY_RESET);
    send_random(150, 1'b1);
    settle();
    write_max_duty(16'($urandom_range(32769, 65535)));
    send_random(100, 1'b0);
    settle();
  endtask

  task automatic test_backpressure();
    rx_hold_req = 1'b1;
    send_random(10, 1'b1);
    rx_hold_req = 1'b0;
    settle();
  endtask

  task automatic test_steady_flow();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_max_duty(16'($urandom_range(0, 65535)));
    send_random(60, 1'b1);
    settle();
  endtask

  // Result side: random stall bursts, plus one long hold when asked
  initial begin
    forever begin
      if (rx_hold_req) begin
        pop <= 1'b0;
        for (int n = 0; n < 400; n++) @(posedge clk_i);
        while (rx_hold_req) begin
          pop <= 1'b1;
          @(posedge clk_i);
        end
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    duties_t exp_d;
    if (rst_ni && pop && !empty) begin
      if (duty_q.size() == 0) begin
        $display("%0t: unexpected word a=%0d b=%0d c=%0d", $time, duty_a_o, duty_b_o,
                 duty_c_o);
        n_errors++;
      end else begin
        exp_d = duty_q.pop_front();
        if (exp_d.a !== duty_a_o || exp_d.b !== duty_b_o || exp_d.c !== duty_c_o) begin
          $display("%0t: mismatch expected a=%0d b=%0d c=%0d actual a=%0d b=%0d c=%0d",
                   $time, exp_d.a, exp_d.b, exp_d.c, duty_a_o, duty_b_o, duty_c_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("svpwm_min_max_duty_calculator_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_max_duty_settings();
    test_random();
    test_backpressure();
    test_steady_flow();
    if (n_errors == 0) begin
      $display("svpwm_min_max_duty_calculator_unit_tb OK");
    end else begin
      $display("svpwm_min_max_duty_calculator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
